// File: rtl/core/dht_pkg.sv
// ----------------------------------------------------------------------------
// Double-hash table engine package
// Shared types and constants: slot marks, operation codes, result status
// codes and the layout of one table entry.
// ----------------------------------------------------------------------------
`default_nettype none

package dht_pkg;

    // Field widths of one input word and one result word.
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned SLOT_W   = 10;
    localparam int unsigned COUNT_W  = 11;

    // Stream data widths, packed from the lowest bit and padded to whole bytes.
    localparam int unsigned IN_BITS  = OPCODE_W + KEY_W + VALUE_W;
    localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_BITS = STATUS_W + SLOT_W + VALUE_W + COUNT_W;
    localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Slot marks.
    localparam int unsigned MARK_W = 2;
    typedef enum logic [MARK_W-1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_USED    = 2'd1,
        MARK_DELETED = 2'd2
    } t_mark;

    // Operation codes. Any other code is treated as a lookup.
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_EXISTS    = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FOUND     = 3'd5
    } t_status;

    // Layout of one memory entry: mark in the low bits, then key, then value.
    localparam int unsigned ENTRY_W  = MARK_W + KEY_W + VALUE_W;
    localparam int unsigned E_KEY_LO = MARK_W;
    localparam int unsigned E_VAL_LO = MARK_W + KEY_W;

endpackage

`default_nettype wire

// File: rtl/core/dht_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dht_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/double_hash_table_engine_top.sv
// ----------------------------------------------------------------------------
// Double-hash table engine
// Open-addressing table of 32-bit keys and values, probed by double hashing,
// with insert, remove and lookup operations, one result word per operation.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Carries
//  ---------+-----------+----------------------------------------------------
//  s        | in        | tdata: opcode[1:0], key[33:2], value[65:34]
//  m        | out       | tdata: status[2:0], slot_index[12:3],
//           |           |        found_value[44:13], entry_count[55:45]
//
// After a word is accepted, the first slot is read (S_ISSUE), slots are probed
// one per cycle through the table memory read port (S_PROBE), and the result
// is moved to the output register (S_RESP); the next word is then taken in
// S_IDLE. A table size that is not a power of two adds the states S_MUL_LO,
// S_MUL_HI and S_REM for the reciprocal multiplications that form the first
// slot and the step. After reset the memory is swept to mark every slot empty,
// during which no word is accepted. A new word is accepted while an earlier
// result still waits in the output register; a finished result then waits
// until that register is free, and no word is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_table_engine_top
    import dht_pkg::*;
#(
    parameter int unsigned TABLE_SIZE = 1024
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Input stream. tdata from bit 0: opcode, key, value, zero padding.
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // Result stream. tdata from bit 0: status, slot_index, found_value,
    // entry_count.
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata
);

    localparam int unsigned AW       = $clog2(TABLE_SIZE);
    localparam int unsigned CW       = $clog2(TABLE_SIZE + 1);
    localparam int unsigned STEP_MOD = TABLE_SIZE >> 3;
    localparam int unsigned STEP_LOG = $clog2(STEP_MOD);
    localparam bit          IS_POW2  = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;

    // Reciprocals for the remainders: m = ceil(2^(32+l) / d) with
    // l = ceil(log2 d) gives the exact quotient of any 32-bit key as
    // (key * m) >> (32 + l). The product is built in two halves of m.
    localparam int unsigned MAG_W    = KEY_W + 1;
    localparam int unsigned MAG_LO_W = 16;
    localparam int unsigned PLO_W    = KEY_W + MAG_LO_W;
    localparam int unsigned PFULL_W  = KEY_W + MAG_W;
    localparam logic [63:0] MAG_A_WIDE =
        ((64'd1 << (KEY_W + AW)) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
    localparam logic [63:0] MAG_B_WIDE =
        ((64'd1 << (KEY_W + STEP_LOG)) + 64'(STEP_MOD - 1)) / 64'(STEP_MOD);
    localparam logic [MAG_W-1:0] MAG_A = MAG_A_WIDE[MAG_W-1:0];
    localparam logic [MAG_W-1:0] MAG_B = MAG_B_WIDE[MAG_W-1:0];

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_LO,
        S_MUL_HI,
        S_REM,
        S_ISSUE,
        S_PROBE,
        S_RESP
    } t_state;

    // Control and payload registers.
    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr_addr, n_clr_addr;
    logic [OPCODE_W-1:0]     r_op, n_op;
    logic [KEY_W-1:0]        r_key, n_key;
    logic [VALUE_W-1:0]      r_value, n_value;
    logic [PLO_W-1:0]        r_prod_a, n_prod_a;
    logic [PLO_W-1:0]        r_prod_b, n_prod_b;
    logic [KEY_W-1:0]        r_quo_a, n_quo_a;
    logic [KEY_W-1:0]        r_quo_b, n_quo_b;
    logic [AW-1:0]           r_pos, n_pos;
    logic [AW-1:0]           r_step, n_step;
    logic [AW-1:0]           r_cnt, n_cnt;
    logic [CW-1:0]           r_used, n_used;
    t_status                 r_res_status, n_res_status;
    logic [AW-1:0]           r_res_slot, n_res_slot;
    logic [VALUE_W-1:0]      r_res_value, n_res_value;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data, n_out_data;

    // Memory port signals.
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic                    ram_re;
    logic [AW-1:0]           ram_raddr;
    logic [ENTRY_W-1:0]      ram_rdata;

    // Decoded read entry and probe helpers.
    t_mark                   rd_mark;
    logic [KEY_W-1:0]        rd_key;
    logic [VALUE_W-1:0]      rd_value;
    logic                    key_hit;
    logic                    probe_last;
    logic [AW:0]             pos_sum;
    logic [AW-1:0]           next_pos;
    logic [KEY_W-1:0]        key_div8;
    logic [PFULL_W-1:0]      full_a;
    logic [PFULL_W-1:0]      full_b;
    logic [KEY_W-1:0]        quo_a;
    logic [KEY_W-1:0]        quo_b;
    logic [KEY_W-1:0]        rem_a;
    logic [KEY_W-1:0]        rem_b;
    logic [KEY_W-1:0]        in_key;
    logic [STATUS_W-1:0]     out_status;
    logic [SLOT_W-1:0]       out_slot;
    logic [COUNT_W-1:0]      out_count;

    dht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_mark  = t_mark'(ram_rdata[MARK_W-1:0]);
    assign rd_key   = ram_rdata[E_KEY_LO +: KEY_W];
    assign rd_value = ram_rdata[E_VAL_LO +: VALUE_W];
    assign key_hit  = rd_key == r_key;
    assign probe_last = r_cnt == AW'(TABLE_SIZE - 1);
    assign in_key   = i_s_tdata[OPCODE_W +: KEY_W];

    // Next probe position: both terms are below the table size, so one
    // compare and subtract wraps the sum.
    assign pos_sum  = {1'b0, r_pos} + {1'b0, r_step};
    assign next_pos = (pos_sum >= (AW+1)'(TABLE_SIZE))
                    ? AW'(pos_sum - (AW+1)'(TABLE_SIZE)) : AW'(pos_sum);

    // Remainders of the key and of the key shifted by three. The upper half
    // of the reciprocal product joins the registered lower half, the quotient
    // is its top part, and the remainder is what the quotient leaves over.
    assign key_div8 = r_key >> 3;
    assign full_a = ((PFULL_W'(r_key) * PFULL_W'(MAG_A[MAG_W-1:MAG_LO_W])) << MAG_LO_W)
                  + PFULL_W'(r_prod_a);
    assign full_b = ((PFULL_W'(key_div8) * PFULL_W'(MAG_B[MAG_W-1:MAG_LO_W])) << MAG_LO_W)
                  + PFULL_W'(r_prod_b);
    assign quo_a  = KEY_W'(full_a >> (KEY_W + AW));
    assign quo_b  = KEY_W'(full_b >> (KEY_W + STEP_LOG));
    assign rem_a  = r_key - r_quo_a * KEY_W'(TABLE_SIZE);
    assign rem_b  = key_div8 - r_quo_b * KEY_W'(STEP_MOD);

    // Result fields, masked or zero-extended to their fixed widths.
    assign out_status = r_res_status;
    assign out_slot   = SLOT_W'(r_res_slot);

    // Next-state and datapath logic.
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_op         = r_op;
        n_key        = r_key;
        n_value      = r_value;
        n_prod_a     = r_prod_a;
        n_prod_b     = r_prod_b;
        n_quo_a      = r_quo_a;
        n_quo_b      = r_quo_b;
        n_pos        = r_pos;
        n_step       = r_step;
        n_cnt        = r_cnt;
        n_used       = r_used;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        out_count    = COUNT_W'(r_used);

        ram_we    = 1'b0;
        ram_waddr = r_pos;
        ram_wdata = {{VALUE_W{1'b0}}, {KEY_W{1'b0}}, MARK_EMPTY};
        ram_re    = 1'b0;
        ram_raddr = r_pos;
        o_s_tready = 1'b0;

        // The downstream side takes the waiting word.
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            // Sweep the memory, marking every slot empty.
            S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(TABLE_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end

            // Take a new word; for a power-of-two table also form the first slot and the step.
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_op    = i_s_tdata[OPCODE_W-1:0];
                    n_key   = in_key;
                    n_value = i_s_tdata[OPCODE_W + KEY_W +: VALUE_W];
                    n_cnt   = '0;
                    if (IS_POW2) begin
                        n_pos   = AW'(in_key & KEY_W'(TABLE_SIZE - 1));
                        n_step  = AW'((in_key >> 3) & KEY_W'(STEP_MOD - 1)) + AW'(1);
                        n_state = S_ISSUE;
                    end else begin
                        n_state = S_MUL_LO;
                    end
                end
            end

            // Lower halves of both reciprocal products.
            S_MUL_LO: begin
                n_prod_a = PLO_W'(r_key) * PLO_W'(MAG_A[MAG_LO_W-1:0]);
                n_prod_b = PLO_W'(key_div8) * PLO_W'(MAG_B[MAG_LO_W-1:0]);
                n_state  = S_MUL_HI;
            end

            // Complete both products and keep the quotients.
            S_MUL_HI: begin
                n_quo_a = quo_a;
                n_quo_b = quo_b;
                n_state = S_REM;
            end

            // First slot and step from the remainders.
            S_REM: begin
                n_pos   = AW'(rem_a);
                n_step  = AW'(rem_b) + AW'(1);
                n_state = S_ISSUE;
            end

            // Read the first slot.
            S_ISSUE: begin
                ram_re    = 1'b1;
                ram_raddr = r_pos;
                n_state   = S_PROBE;
            end

            // Judge the slot just read while the next one is fetched.
            S_PROBE: begin
                ram_re    = 1'b1;
                ram_raddr = next_pos;
                n_pos     = next_pos;
                n_cnt     = r_cnt + AW'(1);
                n_res_slot  = r_pos;
                n_res_value = '0;
                if (r_op == OP_INSERT) begin
                    priority if (rd_mark != MARK_USED) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pos;
                        ram_wdata = {r_value, r_key, MARK_USED};
                        n_used    = r_used + CW'(1);
                        n_res_status = ST_INSERTED;
                        n_state   = S_RESP;
                    end else if (key_hit) begin
                        n_res_status = ST_EXISTS;
                        n_state   = S_RESP;
                    end else if (probe_last) begin
                        n_res_status = ST_FULL;
                        n_res_slot   = '0;
                        n_state   = S_RESP;
                    end
                end else begin
                    priority if (rd_mark == MARK_EMPTY) begin
                        n_res_status = ST_NOT_FOUND;
                        n_res_slot   = '0;
                        n_state   = S_RESP;
                    end else if (rd_mark == MARK_USED && key_hit) begin
                        n_res_value = rd_value;
                        n_state     = S_RESP;
                        if (r_op == OP_REMOVE) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_pos;
                            ram_wdata = {{VALUE_W{1'b0}}, {KEY_W{1'b0}}, MARK_DELETED};
                            if (r_used != '0) begin
                                n_used = r_used - CW'(1);
                            end
                            n_res_status = ST_REMOVED;
                        end else begin
                            n_res_status = ST_FOUND;
                        end
                    end else if (probe_last) begin
                        n_res_status = ST_NOT_FOUND;
                        n_res_slot   = '0;
                        n_state   = S_RESP;
                    end
                end
            end

            // Move the result into the output register once it is free.
            S_RESP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = OUT_TDATA_W'({out_count, r_res_value, out_slot,
                                                out_status});
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_value      <= n_value;
        r_prod_a     <= n_prod_a;
        r_prod_b     <= n_prod_b;
        r_quo_a      <= n_quo_a;
        r_quo_b      <= n_quo_b;
        r_pos        <= n_pos;
        r_step       <= n_step;
        r_cnt        <= n_cnt;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_res_value  <= n_res_value;
        r_out_data   <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Double-hash table engine testbench
// Drives insert, remove and lookup words into the table engine and checks
// every result word against a behavioural copy of the table. The run starts
// with directed words (extreme keys and values, key collisions, deleted slots
// that are skipped or reused, a probe chain that is full) and then sends
// random words over a key pool built to force long probe chains. Both
// channels idle at random, the receiver stalls once for a long stretch, and
// the sender pauses once until the engine has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dht_pkg::*;

    localparam int SLOTS         = 1024;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 2;
    localparam int IDLE_PCT      = 18;
    localparam int RANDOM_ITEMS  = 675;
    localparam int LONG_HOLD     = 2500;
    localparam int HOLD_AFTER    = 120;
    localparam int REPORT_LIMIT  = 10;
    // Longest quiet stretch: the clearing sweep, a full probe run and the long
    // receiver hold, taken several times over.
    localparam int STALL_LIMIT   = 4 * (LONG_HOLD + SLOTS + 32);

    // The spare operation code is not named by the engine; it acts as lookup.
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

    // Low ten key bits that pick the first slot; they also give the largest possible step.
    localparam logic [9:0] DIRECTED_CHAIN = 10'h3F8;
    localparam logic [9:0] RANDOM_CHAIN   = 10'h3FB;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot_index;
        logic [VALUE_W-1:0]  found_value;
        logic [COUNT_W-1:0]  entry_count;
    } t_table_reply;

    // Behavioural copy of the table and the queue of replies it predicts.
    class hash_table_shadow;
        t_mark              marks [SLOTS];
        logic [KEY_W-1:0]   keys_held [SLOTS];
        logic [VALUE_W-1:0] values_held [SLOTS];
        int unsigned        live_entries;
        t_table_reply       pending_replies [$];
        int                 wrong_replies;
        int                 stray_replies;

        function new();
            foreach (marks[i]) begin
                marks[i] = MARK_EMPTY;
                keys_held[i] = '0;
                values_held[i] = '0;
            end
            live_entries = 0;
            wrong_replies = 0;
            stray_replies = 0;
        endfunction

        // Applies one accepted operation word to the copy of the table and
        // queues the reply that the engine must give for it.
        function void note_operation(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key,
                                     logic [VALUE_W-1:0] val);
            t_table_reply reply;
            int unsigned  pos;
            int unsigned  step;
            reply.status = ST_NOT_FOUND;
            reply.slot_index = '0;
            reply.found_value = '0;
            pos = key % SLOTS;
            step = ((key >> 3) % (SLOTS >> 3)) + 1;
            if (op == OP_INSERT) begin
                // Insert stops at the first slot not in use, deleted or empty, or at a used slot holding the key.
                reply.status = ST_FULL;
                for (int n = 0; n < SLOTS; n++) begin
                    if (marks[pos] != MARK_USED) begin
                        marks[pos] = MARK_USED;
                        keys_held[pos] = key;
                        values_held[pos] = val;
                        live_entries++;
                        reply.status = ST_INSERTED;
                        reply.slot_index = SLOT_W'(pos);
                        break;
                    end
                    if (keys_held[pos] == key) begin
                        reply.status = ST_EXISTS;
                        reply.slot_index = SLOT_W'(pos);
                        break;
                    end
                    pos = (pos + step) % SLOTS;
                end
            end else begin
                // Remove and lookup stop at an empty slot or at the used slot holding the key, and skip deleted ones.
                for (int n = 0; n < SLOTS; n++) begin
                    if (marks[pos] == MARK_EMPTY)
                        break;
                    if (marks[pos] == MARK_USED && keys_held[pos] == key) begin
                        reply.slot_index = SLOT_W'(pos);
                        reply.found_value = values_held[pos];
                        if (op == OP_REMOVE) begin
                            marks[pos] = MARK_DELETED;
                            keys_held[pos] = '0;
                            values_held[pos] = '0;
                            if (live_entries > 0)
                                live_entries--;
                            reply.status = ST_REMOVED;
                        end else begin
                            reply.status = ST_FOUND;
                        end
                        break;
                    end
                    pos = (pos + step) % SLOTS;
                end
            end
            reply.entry_count = COUNT_W'(live_entries);
            pending_replies.push_back(reply);
        endfunction

        // Compares one accepted result word with the oldest predicted reply.
        function void check_result(logic [OUT_TDATA_W-1:0] word);
            t_table_reply        want;
            logic [STATUS_W-1:0] got_status;
            logic [SLOT_W-1:0]   got_slot;
            logic [VALUE_W-1:0]  got_value;
            logic [COUNT_W-1:0]  got_count;
            got_status = word[STATUS_W-1:0];
            got_slot   = word[STATUS_W +: SLOT_W];
            got_value  = word[STATUS_W + SLOT_W +: VALUE_W];
            got_count  = word[STATUS_W + SLOT_W + VALUE_W +: COUNT_W];
            if (pending_replies.size() == 0) begin
                stray_replies++;
                if (wrong_replies + stray_replies <= REPORT_LIMIT)
                    $display("[%0t] result word with no operation outstanding: %h",
                             $time, word);
                return;
            end
            want = pending_replies.pop_front();
            if (got_status !== want.status || got_slot !== want.slot_index ||
                got_value !== want.found_value || got_count !== want.entry_count) begin
                wrong_replies++;
                if (wrong_replies + stray_replies <= REPORT_LIMIT) begin
                    $write("[%0t] result mismatch (expected/actual): status %0d/%0d",
                           $time, want.status, got_status);
                    $display(" slot %0d/%0d value %h/%h count %0d/%0d",
                             want.slot_index, got_slot, want.found_value, got_value,
                             want.entry_count, got_count);
                end
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    // Fields from bit 0: opcode, key, value, zero padding.
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    // Fields from bit 0: status, slot_index, found_value, entry_count.
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    hash_table_shadow shadow;
    int               results_seen = 0;
    bit               steady_phase = 1'b0;

    double_hash_table_engine_top #(
        .TABLE_SIZE (SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Offers one operation word after a random idle gap and holds it until
    // the engine takes it.
    task automatic send_operation(logic [OPCODE_W-1:0] op, logic [KEY_W-1:0] key,
                                  logic [VALUE_W-1:0] val);
        int gap;
        gap = 0;
        while (!steady_phase && $urandom_range(99) < IDLE_PCT)
            gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TDATA_W'({val, key, op});
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Withdraws the input and waits until every predicted reply has come back.
    task automatic wait_until_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (shadow.pending_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // Both channels are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                shadow.note_operation(i_s_tdata[OPCODE_W-1:0], i_s_tdata[OPCODE_W +: KEY_W],
                                      i_s_tdata[OPCODE_W + KEY_W +: VALUE_W]);
            if (o_m_tvalid && i_m_tready) begin
                shadow.check_result(o_m_tdata);
                results_seen++;
            end
        end
    end

    // Result receiver: random back-pressure, one long hold while the sender
    // keeps offering, and no back-pressure during the steady phase.
    initial begin : result_sink
        bit held;
        held = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            i_m_tready <= steady_phase || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Ends the run when no word has moved on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [KEY_W-1:0]    tight_keys [10];
        logic [KEY_W-1:0]    cluster_keys [16];
        logic [KEY_W-1:0]    mixed_keys [14];
        logic [KEY_W-1:0]    key;
        logic [OPCODE_W-1:0] op;
        int unsigned         pick;
        int                  failures;
        shadow = new();
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Extreme keys and values, a repeated insert, and the spare code.
        send_operation(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_operation(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
        send_operation(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
        send_operation(OP_LOOKUP, 32'h0000_0000, 32'h0);
        send_operation(OP_SPARE,  32'hFFFF_FFFF, 32'h0);
        // Key 1024 shares slot 0 with key 0 and steps by one.
        send_operation(OP_LOOKUP, 32'd1024, 32'h0);
        send_operation(OP_INSERT, 32'd1024, 32'h5A5A_5A5A);
        send_operation(OP_REMOVE, 32'h0000_0000, 32'h0);
        // The deleted slot is skipped by lookup and reused by insert, so the
        // key ends up held twice.
        send_operation(OP_LOOKUP, 32'd1024, 32'h0);
        send_operation(OP_INSERT, 32'd1024, 32'hA5A5_A5A5);
        send_operation(OP_REMOVE, 32'd1024, 32'h0);
        send_operation(OP_LOOKUP, 32'd1024, 32'h0);
        send_operation(OP_REMOVE, 32'h0000_0000, 32'h0);

        // These keys visit only eight slots: fill them, then run out of probes.
        for (int i = 0; i < 8; i++)
            send_operation(OP_INSERT, {22'(i + 1), DIRECTED_CHAIN}, $urandom);
        send_operation(OP_INSERT, {22'd9, DIRECTED_CHAIN}, $urandom);
        send_operation(OP_LOOKUP, {22'd9, DIRECTED_CHAIN}, 32'h0);
        send_operation(OP_REMOVE, {22'd1, DIRECTED_CHAIN}, 32'h0);
        send_operation(OP_INSERT, {22'd9, DIRECTED_CHAIN}, $urandom);

        // Key pool: a group that overfills its eight slots, a group with
        // neighbouring first slots and a shared step, and unrelated keys.
        foreach (tight_keys[i])
            tight_keys[i] = {22'($urandom), RANDOM_CHAIN};
        foreach (cluster_keys[i])
            cluster_keys[i] = {22'($urandom), 7'h20, 3'($urandom)};
        foreach (mixed_keys[i])
            mixed_keys[i] = $urandom;

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_phase = (n >= 200 && n < 320);
            if (n == 450)
                wait_until_drained();
            pick = $urandom_range(99);
            if (pick < 12)
                key = tight_keys[$urandom_range(9)];
            else if (pick < 52)
                key = cluster_keys[$urandom_range(15)];
            else if (pick < 85)
                key = mixed_keys[$urandom_range(13)];
            else
                key = $urandom;
            pick = $urandom_range(99);
            if (pick < 42)
                op = OP_INSERT;
            else if (pick < 67)
                op = OP_REMOVE;
            else if (pick < 95)
                op = OP_LOOKUP;
            else
                op = OP_SPARE;
            send_operation(op, key, $urandom);
        end

        // Drain, then allow for the longest probe run before judging.
        wait_until_drained();
        repeat (SLOTS + 16) @(posedge i_clk);
        failures = shadow.wrong_replies + shadow.stray_replies +
                   shadow.pending_replies.size();
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
